[rtl/pjsg_pkg.sv]
// Shared constants and types for the progressive jittered sample generator.
package pjsg_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int RAND_W       = 16;
    localparam int COORD_OUT_W  = 16;
    localparam int SAMPLE_IDX_W = 12;
    localparam int TARGET_W     = 13;
    localparam int LEVEL_W      = 3;

    // Sequence positions reach 4 * 4^7 - 1 at the deepest level.
    localparam int IDX_W     = 16;
    localparam int TGT_CMP_W = IDX_W + 1;

    // Each expansion computes three new samples.
    localparam int NEW_PER_ITEM = 3;
    localparam int STEP_W       = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_COORD_BITS  = 16;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd1;

    // One expansion job handed from the sequence control to the expansion unit.
    typedef struct packed {
        logic                                   first;
        logic [LEVEL_W-1:0]                     level;
        logic [IDX_W-1:0]                       walk;
        logic [NEW_PER_ITEM-1:0][IDX_W-1:0]     idx;
        logic [NEW_PER_ITEM-1:0]                wr_en;
        logic [NEW_PER_ITEM-1:0]                emit;
        logic                                   finished;
        logic                                   flip;
        logic [NEW_PER_ITEM-1:0][RAND_W-1:0]    rand_x;
        logic [NEW_PER_ITEM-1:0][RAND_W-1:0]    rand_y;
    } pjsg_item_t;

endpackage

[rtl/pjsg_if.sv]
// Channel interfaces: random words in, samples out, and the target write port.
interface pjsg_rand_if;
    logic                          valid;
    logic                          ready;
    logic [pjsg_pkg::RAND_W-1:0]   rand_x_first;
    logic [pjsg_pkg::RAND_W-1:0]   rand_y_first;
    logic [pjsg_pkg::RAND_W-1:0]   rand_x_second;
    logic [pjsg_pkg::RAND_W-1:0]   rand_y_second;
    logic [pjsg_pkg::RAND_W-1:0]   rand_x_third;
    logic [pjsg_pkg::RAND_W-1:0]   rand_y_third;
    logic                          flip_choice;

    modport source (
        output valid, rand_x_first, rand_y_first, rand_x_second, rand_y_second,
               rand_x_third, rand_y_third, flip_choice,
        input  ready
    );
    modport sink (
        input  valid, rand_x_first, rand_y_first, rand_x_second, rand_y_second,
               rand_x_third, rand_y_third, flip_choice,
        output ready
    );
endinterface

interface pjsg_sample_if;
    logic                                valid;
    logic                                ready;
    logic [pjsg_pkg::SAMPLE_IDX_W-1:0]   sample_index;
    logic [pjsg_pkg::COORD_OUT_W-1:0]    coord_x;
    logic [pjsg_pkg::COORD_OUT_W-1:0]    coord_y;
    logic                                last_of_run;
    logic                                finished;

    modport source (
        output valid, sample_index, coord_x, coord_y, last_of_run, finished,
        input  ready
    );
    modport sink (
        input  valid, sample_index, coord_x, coord_y, last_of_run, finished,
        output ready
    );
endinterface

interface pjsg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pjsg_pkg::TARGET_W-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

[rtl/progressive_jittered_sample_generator_unit.sv]
// Progressive jittered 2-D sample generator: sequence control and expansion unit.
// An item passes through the read stage, the write-back stage and the result register.
// Items are paced by the three write-backs per item on the sample store's single
// write port; a stalled result channel slows them further.
// Reset clears the sequence state and sets the target to 1; store contents stay
// undefined until written and need no clearing pass.
module progressive_jittered_sample_generator_unit #(
    parameter int MAX_SAMPLES = pjsg_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_BITS  = pjsg_pkg::DEF_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    pjsg_cfg_if.sink      cfg_ch,
    pjsg_rand_if.sink     rand_ch,
    pjsg_sample_if.source sample_ch
);

    localparam int IW = pjsg_pkg::IDX_W;
    localparam int TW = pjsg_pkg::TGT_CMP_W;

    logic [pjsg_pkg::TARGET_W-1:0]  target_reg;
    logic [pjsg_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [IW-1:0]                  walk_reg, walk_next;
    logic                           started_reg, started_next;
    logic                           complete_reg, complete_next;

    logic                           item_ready;
    logic                           item_push;
    logic                           rand_xfer;
    pjsg_pkg::pjsg_item_t           item;

    logic [TW-1:0]                  eff_target;
    logic [IW-1:0]                  count;
    logic [IW-1:0]                  walk_inc;
    logic [IW-1:0]                  idx0;
    logic [IW-1:0]                  idx1;
    logic [IW-1:0]                  idx2;

    assign cfg_ch.ready  = 1'b1;
    assign rand_ch.ready = item_ready;
    assign rand_xfer     = rand_ch.valid && item_ready;
    assign item_push     = rand_xfer && !complete_reg;

    // Effective target, level geometry and the three new positions.
    always_comb
    begin
        eff_target = TW'(target_reg);
        if (target_reg == '0)
        begin
            eff_target = TW'(1);
        end
        else if (eff_target > TW'(MAX_SAMPLES))
        begin
            eff_target = TW'(MAX_SAMPLES);
        end

        count    = IW'(1) << {level_reg, 1'b0};
        walk_inc = walk_reg + IW'(1);
        idx0     = count + walk_reg;
        idx1     = (count << 1) + walk_reg;
        idx2     = idx0 + (count << 1);
    end

    // Sequence state update, made when an item is transferred.
    always_comb
    begin
        level_next    = level_reg;
        walk_next     = walk_reg;
        started_next  = started_reg;
        complete_next = complete_reg;

        if (item_push)
        begin
            if (!started_reg)
            begin
                started_next  = 1'b1;
                complete_next = (eff_target <= TW'(1));
            end
            else if (walk_inc >= count)
            begin
                // End of a level: go deeper only if the target needs more samples.
                if (eff_target <= (TW'(count) << 2))
                begin
                    complete_next = 1'b1;
                end
                else
                begin
                    level_next = level_reg + pjsg_pkg::LEVEL_W'(1);
                    walk_next  = '0;
                end
            end
            else
            begin
                walk_next     = walk_inc;
                complete_next = (eff_target <= TW'(idx0) + TW'(1));
            end
        end
    end

    // Job handed to the expansion unit.
    always_comb
    begin
        item.first    = !started_reg;
        item.level    = level_reg;
        item.walk     = walk_reg;
        item.idx      = {idx2, idx1, idx0};
        item.flip     = rand_ch.flip_choice;
        item.finished = complete_next;
        item.rand_x   = {rand_ch.rand_x_third, rand_ch.rand_x_second, rand_ch.rand_x_first};
        item.rand_y   = {rand_ch.rand_y_third, rand_ch.rand_y_second, rand_ch.rand_y_first};
        item.emit[0]  = TW'(idx0) < eff_target;
        item.emit[1]  = TW'(idx1) < eff_target;
        item.emit[2]  = TW'(idx2) < eff_target;
        item.wr_en[0] = TW'(idx0) < TW'(MAX_SAMPLES);
        item.wr_en[1] = TW'(idx1) < TW'(MAX_SAMPLES);
        item.wr_en[2] = TW'(idx2) < TW'(MAX_SAMPLES);

        // The first item only places sample 0, which is kept outside the store.
        if (!started_reg)
        begin
            item.idx   = '0;
            item.emit  = 3'b001;
            item.wr_en = '0;
        end
    end

    // Sequence state and target register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= pjsg_pkg::TARGET_RESET;
            level_reg    <= '0;
            walk_reg     <= '0;
            started_reg  <= 1'b0;
            complete_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                target_reg <= cfg_ch.data;
            end
            level_reg    <= level_next;
            walk_reg     <= walk_next;
            started_reg  <= started_next;
            complete_reg <= complete_next;
        end
    end

    pjsg_expand #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .COORD_BITS  (COORD_BITS)
    ) u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_push  (item_push),
        .item       (item),
        .item_ready (item_ready),
        .sample_ch  (sample_ch)
    );

endmodule

[rtl/pjsg_expand.sv]
// Expansion unit: sample store, new-sample arithmetic, write-back and result register.
module pjsg_expand #(
    parameter int MAX_SAMPLES = pjsg_pkg::DEF_MAX_SAMPLES,
    parameter int COORD_BITS  = pjsg_pkg::DEF_COORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_push,
    input  pjsg_pkg::pjsg_item_t item,
    output logic                 item_ready,
    pjsg_sample_if.source        sample_ch
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CB     = COORD_BITS;
    localparam int WORD_W = 2 * CB;
    localparam int NP     = pjsg_pkg::NEW_PER_ITEM;
    localparam int SW     = pjsg_pkg::STEP_W;

    // Scale a 16-bit random word to a CB-bit fraction.
    function automatic logic [CB-1:0] rand_to_coord(input logic [pjsg_pkg::RAND_W-1:0] r);
        logic [pjsg_pkg::RAND_W+CB-1:0] wide;
        wide = {r, {CB{1'b0}}};
        return wide[pjsg_pkg::RAND_W+CB-1 -: CB];
    endfunction

    // Scale a CB-bit fraction to the 16-bit output format.
    function automatic logic [pjsg_pkg::COORD_OUT_W-1:0] coord_to_out(input logic [CB-1:0] v);
        logic [CB+pjsg_pkg::COORD_OUT_W-1:0] wide;
        wide = {v, {pjsg_pkg::COORD_OUT_W{1'b0}}};
        return wide[CB+pjsg_pkg::COORD_OUT_W-1 -: pjsg_pkg::COORD_OUT_W];
    endfunction

    // Keep the cell bits, set the half-cell bit, and fill the rest with jitter.
    function automatic logic [CB-1:0] make_coord(
        input logic [CB-1:0]                  old,
        input logic [pjsg_pkg::LEVEL_W-1:0]   lvl,
        input logic                           half,
        input logic [pjsg_pkg::RAND_W-1:0]    r
    );
        logic [CB-1:0] keep;
        logic [CB-1:0] hbit;
        logic [CB-1:0] jit;
        keep = ~({CB{1'b1}} >> lvl);
        hbit = {1'b1, {(CB-1){1'b0}}} >> lvl;
        jit  = rand_to_coord(r) >> ({1'b0, lvl} + 4'd1);
        return (old & keep) | (half ? hbit : '0) | jit;
    endfunction

    // Sample store: x in the upper half of a word, y in the lower half.
    logic [WORD_W-1:0]              store_mem [MAX_SAMPLES];
    logic [WORD_W-1:0]              rd_data_reg;
    logic [WORD_W-1:0]              seed_reg;

    // Read stage.
    logic                           rd_valid_reg, rd_valid_next;
    pjsg_pkg::pjsg_item_t           rd_item_reg;

    // Write-back stage.
    logic                           buf_valid_reg, buf_valid_next;
    logic [SW-1:0]                  step_reg, step_next;
    logic [NP-1:0][CB-1:0]          res_x_reg;
    logic [NP-1:0][CB-1:0]          res_y_reg;
    logic [NP-1:0][pjsg_pkg::IDX_W-1:0] buf_idx_reg;
    logic [NP-1:0]                  buf_emit_reg;
    logic [NP-1:0]                  buf_wr_reg;
    logic [NP-1:0]                  buf_last_reg;
    logic                           buf_finished_reg;

    // Result register.
    logic                           out_valid_reg, out_valid_next;
    logic [pjsg_pkg::SAMPLE_IDX_W-1:0] out_idx_reg;
    logic [pjsg_pkg::COORD_OUT_W-1:0]  out_x_reg;
    logic [pjsg_pkg::COORD_OUT_W-1:0]  out_y_reg;
    logic                           out_last_reg;
    logic                           out_finished_reg;

    logic                           out_free;
    logic                           step_emit;
    logic                           step_adv;
    logic                           out_load;
    logic                           buf_done;
    logic                           rd_move;

    logic [WORD_W-1:0]              old_word;
    logic [CB-1:0]                  old_x;
    logic [CB-1:0]                  old_y;
    logic [CB-1:0]                  half_mask;
    logic [NP-1:0]                  half_x;
    logic [NP-1:0]                  half_y;
    logic [NP-1:0][CB-1:0]          new_x;
    logic [NP-1:0][CB-1:0]          new_y;
    logic [NP-1:0]                  new_last;

    // Stage handshakes: the write-back stage steps once per new sample.
    always_comb
    begin
        out_free   = !out_valid_reg || sample_ch.ready;
        step_emit  = buf_emit_reg[step_reg];
        step_adv   = buf_valid_reg && (!step_emit || out_free);
        out_load   = step_adv && step_emit;
        buf_done   = step_adv && (step_reg == SW'(NP - 1));
        rd_move    = rd_valid_reg && (!buf_valid_reg || buf_done);
        item_ready = !rd_valid_reg || rd_move;
    end

    // New sample arithmetic from the old sample of the read stage.
    always_comb
    begin
        old_word  = (rd_item_reg.walk == '0) ? seed_reg : rd_data_reg;
        old_x     = old_word[WORD_W-1:CB];
        old_y     = old_word[CB-1:0];
        half_mask = {1'b1, {(CB-1){1'b0}}} >> rd_item_reg.level;

        half_x[0] = ~|(old_x & half_mask);
        half_y[0] = ~|(old_y & half_mask);
        half_x[1] = rd_item_reg.flip ? ~half_x[0] : half_x[0];
        half_y[1] = rd_item_reg.flip ? half_y[0] : ~half_y[0];
        half_x[2] = ~half_x[1];
        half_y[2] = ~half_y[1];

        for (int k = 0; k < NP; k++)
        begin
            new_x[k] = make_coord(old_x, rd_item_reg.level, half_x[k], rd_item_reg.rand_x[k]);
            new_y[k] = make_coord(old_y, rd_item_reg.level, half_y[k], rd_item_reg.rand_y[k]);
        end

        // The very first sample is placed directly from the random words.
        if (rd_item_reg.first)
        begin
            new_x[0] = rand_to_coord(rd_item_reg.rand_x[0]);
            new_y[0] = rand_to_coord(rd_item_reg.rand_y[0]);
        end

        // Emitted results form a prefix; the last of them closes the run.
        for (int k = 0; k < NP - 1; k++)
        begin
            new_last[k] = rd_item_reg.emit[k] && !rd_item_reg.emit[k+1];
        end
        new_last[NP-1] = rd_item_reg.emit[NP-1];
    end

    // Next values of the stage control.
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (item_push)
        begin
            rd_valid_next = 1'b1;
        end
        else if (rd_move)
        begin
            rd_valid_next = 1'b0;
        end

        buf_valid_next = buf_valid_reg;
        step_next      = step_reg;
        if (rd_move)
        begin
            buf_valid_next = 1'b1;
            step_next      = '0;
        end
        else if (buf_done)
        begin
            buf_valid_next = 1'b0;
            step_next      = '0;
        end
        else if (step_adv)
        begin
            step_next = step_reg + SW'(1);
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            buf_valid_reg <= buf_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Store read port: the old sample is fetched as the job is taken.
    always_ff @(posedge clk)
    begin
        if (item_push)
        begin
            rd_data_reg <= store_mem[item.walk[ADDR_W-1:0]];
        end
    end

    // Store write port: at most one new sample written back per step.
    always_ff @(posedge clk)
    begin
        if (step_adv && buf_wr_reg[step_reg])
        begin
            store_mem[buf_idx_reg[step_reg][ADDR_W-1:0]] <=
                {res_x_reg[step_reg], res_y_reg[step_reg]};
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (item_push)
        begin
            rd_item_reg <= item;
        end
        if (rd_move)
        begin
            res_x_reg        <= new_x;
            res_y_reg        <= new_y;
            buf_idx_reg      <= rd_item_reg.idx;
            buf_emit_reg     <= rd_item_reg.emit;
            buf_wr_reg       <= rd_item_reg.wr_en;
            buf_last_reg     <= new_last;
            buf_finished_reg <= rd_item_reg.finished;
            if (rd_item_reg.first)
            begin
                seed_reg <= {new_x[0], new_y[0]};
            end
        end
        if (out_load)
        begin
            out_idx_reg      <= buf_idx_reg[step_reg][pjsg_pkg::SAMPLE_IDX_W-1:0];
            out_x_reg        <= coord_to_out(res_x_reg[step_reg]);
            out_y_reg        <= coord_to_out(res_y_reg[step_reg]);
            out_last_reg     <= buf_last_reg[step_reg];
            out_finished_reg <= buf_finished_reg;
        end
    end

    // Result channel.
    assign sample_ch.valid        = out_valid_reg;
    assign sample_ch.sample_index = out_idx_reg;
    assign sample_ch.coord_x      = out_x_reg;
    assign sample_ch.coord_y      = out_y_reg;
    assign sample_ch.last_of_run  = out_last_reg;
    assign sample_ch.finished     = out_finished_reg;

endmodule

[verif/progressive_jittered_sample_generator_unit_tb.sv]
// Self-checking testbench for the progressive jittered sample generator.
module progressive_jittered_sample_generator_unit_tb;

    import pjsg_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_WAIT  = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int TARGET_MAX   = 8191;
    localparam int STORE_DEPTH  = DEF_MAX_SAMPLES;

    // One set of random words offered to the block.
    typedef struct packed {
        logic [RAND_W-1:0] x_first;
        logic [RAND_W-1:0] y_first;
        logic [RAND_W-1:0] x_second;
        logic [RAND_W-1:0] y_second;
        logic [RAND_W-1:0] x_third;
        logic [RAND_W-1:0] y_third;
        logic              flip;
    } rand_words_t;

    // One emitted sample as the result channel carries it.
    typedef struct packed {
        logic [SAMPLE_IDX_W-1:0] index;
        logic [COORD_OUT_W-1:0]  x;
        logic [COORD_OUT_W-1:0]  y;
        logic                    last_of_run;
        logic                    finished;
    } sample_t;

    logic clk;
    logic rst_n;

    pjsg_cfg_if    cfg_ch ();
    pjsg_rand_if   rand_ch ();
    pjsg_sample_if sample_ch ();

    progressive_jittered_sample_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_ch    (cfg_ch),
        .rand_ch   (rand_ch),
        .sample_ch (sample_ch)
    );

    // Predicted sequence state, kept in step with accepted transfers.
    logic [TARGET_W-1:0]    target_reg = TARGET_RESET;
    logic [COORD_OUT_W-1:0] store_x [STORE_DEPTH];
    logic [COORD_OUT_W-1:0] store_y [STORE_DEPTH];
    int                     seq_level = 0;
    int                     seq_walk = 0;
    bit                     seq_started = 1'b0;
    bit                     seq_done = 1'b0;

    sample_t expected_samples [$];
    sample_t head_sample;

    int  error_count = 0;
    int  items_sent = 0;
    int  ignored_items = 0;
    int  samples_checked = 0;
    int  target_writes = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  idle_left = 0;
    bit  quiet = 1'b0;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("** progressive_jittered_sample_generator_unit: FAILED **");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("sample %0d field %s got 0x%0h expected 0x%0h",
                                   head_sample.index, name, got, want));
    endtask

    // Mostly short gaps, now and then a long one; none while quiet.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random word with extra weight on all zeros and all ones.
    function automatic logic [RAND_W-1:0] biased_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return RAND_W'($urandom_range(0, 65535));
    endfunction

    function automatic rand_words_t random_words();
        rand_words_t w;
        w.x_first  = biased_word();
        w.y_first  = biased_word();
        w.x_second = biased_word();
        w.y_second = biased_word();
        w.x_third  = biased_word();
        w.y_third  = biased_word();
        w.flip     = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Target as the block uses it: zero means one, large values saturate.
    function automatic int active_target();
        int t;
        t = int'(target_reg);
        if (t == 0)
            t = 1;
        if (t > STORE_DEPTH)
            t = STORE_DEPTH;
        return t;
    endfunction

    // Keep the cell of the old coordinate, set the half bit, jitter below it.
    function automatic int unsigned jitter_coord(input int unsigned old, input int lvl,
                                                 input int unsigned half,
                                                 input int unsigned r);
        int sh;
        sh = COORD_OUT_W - lvl;
        return (((old >> sh) << sh) | ((half & 1) << (sh - 1)) | (r >> (lvl + 1)))
               & 32'hFFFF;
    endfunction

    // Advances the sequence by one accepted item and queues the samples it emits.
    task automatic predict_expansion(input rand_words_t w);
        sample_t     made [NEW_PER_ITEM];
        int          n;
        int          tgt;
        int          cnt;
        int          s;
        int          hb;
        int          idx;
        int          k;
        int unsigned ox;
        int unsigned oy;
        int unsigned hx;
        int unsigned hy;
        int unsigned cx;
        int unsigned cy;
        int unsigned wx [NEW_PER_ITEM];
        int unsigned wy [NEW_PER_ITEM];
        n = 0;
        tgt = active_target();
        if (seq_done)
        begin
            ignored_items++;
            return;
        end
        if (!seq_started)
        begin
            // The very first item places sample 0 directly.
            store_x[0] = w.x_first;
            store_y[0] = w.y_first;
            seq_started = 1'b1;
            made[0].index = '0;
            made[0].x = w.x_first;
            made[0].y = w.y_first;
            n = 1;
            if (tgt <= 1)
                seq_done = 1'b1;
        end
        else
        begin
            cnt = 1 << (2 * seq_level);
            s = seq_walk;
            if (s >= cnt)
                s = 0;
            ox = 32'(store_x[s]);
            oy = 32'(store_y[s]);
            hb = COORD_OUT_W - 1 - seq_level;
            hx = 1 - ((ox >> hb) & 1);
            hy = 1 - ((oy >> hb) & 1);
            wx[0] = 32'(w.x_first);
            wx[1] = 32'(w.x_second);
            wx[2] = 32'(w.x_third);
            wy[0] = 32'(w.y_first);
            wy[1] = 32'(w.y_second);
            wy[2] = 32'(w.y_third);
            // Three children, each in another half-cell quadrant of the parent.
            for (k = 0; k < NEW_PER_ITEM; k++)
            begin
                if (k == 1)
                begin
                    if (w.flip)
                        hx ^= 1;
                    else
                        hy ^= 1;
                end
                else if (k == 2)
                begin
                    hx ^= 1;
                    hy ^= 1;
                end
                cx = jitter_coord(ox, seq_level, hx, wx[k]);
                cy = jitter_coord(oy, seq_level, hy, wy[k]);
                idx = (k + 1) * cnt + s;
                if (idx < STORE_DEPTH)
                begin
                    store_x[idx] = COORD_OUT_W'(cx);
                    store_y[idx] = COORD_OUT_W'(cy);
                end
                if (idx < tgt)
                begin
                    made[n].index = SAMPLE_IDX_W'(idx);
                    made[n].x = COORD_OUT_W'(cx);
                    made[n].y = COORD_OUT_W'(cy);
                    n++;
                end
            end
            // Walk on through the level, or move to the next one, or stop.
            if (s + 1 >= cnt)
            begin
                if (tgt <= 4 * cnt)
                    seq_done = 1'b1;
                else
                begin
                    seq_level = (seq_level + 1) & 7;
                    seq_walk = 0;
                end
            end
            else
            begin
                seq_walk = s + 1;
                if (tgt <= cnt + s + 1)
                    seq_done = 1'b1;
            end
        end
        for (k = 0; k < n; k++)
        begin
            made[k].finished = seq_done;
            made[k].last_of_run = (k == n - 1);
            expected_samples.push_back(made[k]);
        end
    endtask

    // Offers one item; entered and left at a falling edge, valid left high.
    task automatic send_words(input rand_words_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rand_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rand_ch.valid         <= 1'b1;
        rand_ch.rand_x_first  <= w.x_first;
        rand_ch.rand_y_first  <= w.y_first;
        rand_ch.rand_x_second <= w.x_second;
        rand_ch.rand_y_second <= w.y_second;
        rand_ch.rand_x_third  <= w.x_third;
        rand_ch.rand_y_third  <= w.y_third;
        rand_ch.flip_choice   <= w.flip;
        @(posedge clk);
        while (!rand_ch.ready)
            @(posedge clk);
        predict_expansion(w);
        items_sent++;
        @(negedge clk);
    endtask

    // Writes the target once the block has drained; entered and left at a falling edge.
    task automatic write_target(input logic [TARGET_W-1:0] value);
        rand_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        target_reg = value;
        target_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sample 0 from extreme words, with a target that keeps the run going.
    task automatic test_first_sample();
        write_target(13'd2);
        send_words('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    endtask

    // A small target lets only some of the new samples out at level 1.
    task automatic test_partial_emission();
        write_target(13'd10);
        send_words('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
        send_words('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
        send_words('{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000, 1'b1});
        send_words('{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 1'b0});
    endtask

    // Exact store depth, then the largest register value, which saturates.
    task automatic test_target_limits();
        write_target(13'd4096);
        send_words('{16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE, 16'h0001, 16'h8000, 1'b1});
        write_target(TARGET_W'(TARGET_MAX));
        repeat (6) send_words(random_words());
    endtask

    // A mid-run target that cuts off the upper children at level 2.
    task automatic test_midrun_target();
        write_target(13'd40);
        repeat (6) send_words(random_words());
    endtask

    // The result side holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        write_target(TARGET_W'(TARGET_MAX));
        quiet = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (12) send_words(random_words());
        quiet = 1'b0;
    endtask

    // Random words in chunks, each with a target that cannot end the run early.
    task automatic test_random_items();
        int chunk;
        int lo;
        int value;
        for (chunk = 0; chunk < 5; chunk++)
        begin
            lo = 16 * (1 << (2 * seq_level)) + 1;
            case ($urandom_range(0, 3))
                0: value = TARGET_MAX;
                1: value = (lo <= STORE_DEPTH) ? STORE_DEPTH : TARGET_MAX;
                default: value = $urandom_range(lo, TARGET_MAX);
            endcase
            write_target(TARGET_W'(value));
            quiet = (chunk == 2);
            repeat (20) send_words(random_words());
        end
        quiet = 1'b0;
    endtask

    // Target zero ends the run; the completing item and later ones emit nothing.
    task automatic test_completion();
        write_target(13'd0);
        repeat (4) send_words(random_words());
    endtask

    // Result sink: random ready, with one long hold-off when requested.
    initial
    begin
        sample_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                sample_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (idle_left > 0)
            begin
                sample_ch.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                idle_left = pick_gap();
                if (idle_left > 0)
                begin
                    sample_ch.ready <= 1'b0;
                    idle_left--;
                end
                else
                    sample_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest expected sample.
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            if (expected_samples.size() == 0)
                report_error($sformatf("unexpected sample %0d", sample_ch.sample_index));
            else
            begin
                head_sample = expected_samples.pop_front();
                check_field("sample_index", int'(sample_ch.sample_index),
                            int'(head_sample.index));
                check_field("coord_x", int'(sample_ch.coord_x), int'(head_sample.x));
                check_field("coord_y", int'(sample_ch.coord_y), int'(head_sample.y));
                check_field("last_of_run", int'(sample_ch.last_of_run),
                            int'(head_sample.last_of_run));
                check_field("finished", int'(sample_ch.finished),
                            int'(head_sample.finished));
                samples_checked++;
            end
        end
    end

    // Reset, directed tests, random traffic, then drain and verdict.
    initial
    begin
        int waited;
        rand_ch.valid         = 1'b0;
        rand_ch.rand_x_first  = '0;
        rand_ch.rand_y_first  = '0;
        rand_ch.rand_x_second = '0;
        rand_ch.rand_y_second = '0;
        rand_ch.rand_x_third  = '0;
        rand_ch.rand_y_third  = '0;
        rand_ch.flip_choice   = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        rst_n                 = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_partial_emission();
        test_target_limits();
        test_midrun_target();
        test_backpressure();
        test_random_items();
        test_completion();

        rand_ch.valid <= 1'b0;
        waited = 0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (expected_samples.size() != 0)
            report_error($sformatf("%0d expected samples never arrived",
                                   expected_samples.size()));

        $display("Covered %0d items (%0d after completion), %0d samples checked,",
                 items_sent, ignored_items, samples_checked);
        $display("%0d target writes, deepest level %0d, %0d mismatches.",
                 target_writes, seq_level, error_count);
        if (error_count == 0)
            $display("** progressive_jittered_sample_generator_unit: PASSED **");
        else
            $display("** progressive_jittered_sample_generator_unit: FAILED **");
        $finish;
    end

endmodule
